FILE: sv/wcb_pkg.sv
// ----------------------------------------------------------------------------
// Write-combining buffer package
// Shared sizes, item types and the line start command for the flash
// write-combining buffer.
// ----------------------------------------------------------------------------
package wcb_pkg;

    // Words per flash line and the widths that follow from it.
    localparam int LINE_WORDS = 8;
    localparam int SLOT_W     = $clog2(LINE_WORDS);
    localparam int CNT_W      = $clog2(LINE_WORDS + 1);
    localparam int RAM_AW     = SLOT_W + 1;
    localparam int RAM_DEPTH  = 2 ** RAM_AW;
    localparam int WORD_W     = 32;

    // Word written into slots of a line that were never filled.
    localparam logic [WORD_W-1:0] PAD_WORD = {WORD_W{1'b1}};

    // Item modes.
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // Input item.
    typedef struct packed {
        logic              mode;
        logic [WORD_W-1:0] byte_address;
        logic [WORD_W-1:0] data_word;
    } t_in_item;

    // Result item, one per word of an emitted line.
    typedef struct packed {
        logic [WORD_W-1:0] line_address;
        logic [2:0]        slot_index;
        logic [WORD_W-1:0] line_word;
        logic              last_of_line;
    } t_out_item;

    // Command from the fill control to the drain sequencer.
    typedef struct packed {
        logic              valid;
        logic              bank;
        logic [WORD_W-1:0] base;
        logic [CNT_W-1:0]  fill;
    } t_drain_cmd;

endpackage

FILE: sv/wcb_line_ram.sv
// ----------------------------------------------------------------------------
// Line word memory
// Two banks of line words: one bank fills while the other drains. One write
// port and one read port with registered read data and a read enable.
// ----------------------------------------------------------------------------
module wcb_line_ram (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [wcb_pkg::RAM_AW-1:0] i_waddr,
    input  logic [wcb_pkg::WORD_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [wcb_pkg::RAM_AW-1:0] i_raddr,
    output logic [wcb_pkg::WORD_W-1:0] o_rdata
);

    logic [wcb_pkg::WORD_W-1:0] r_mem [wcb_pkg::RAM_DEPTH];
    logic [wcb_pkg::WORD_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds while the read enable is low.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/wcb_fill_ctrl.sv
// ----------------------------------------------------------------------------
// Fill control
// Accepts items, writes data words into the filling bank, tracks the line
// base and fill count, and hands finished lines to the drain sequencer.
// ----------------------------------------------------------------------------
module wcb_fill_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  wcb_pkg::t_in_item          i_item,
    output logic                       o_stall,
    input  logic                       i_drain_free,
    output wcb_pkg::t_drain_cmd        o_cmd,
    output logic                       o_we,
    output logic [wcb_pkg::RAM_AW-1:0] o_waddr,
    output logic [wcb_pkg::WORD_W-1:0] o_wdata
);

    logic [wcb_pkg::CNT_W-1:0]  r_fill;
    logic [wcb_pkg::CNT_W-1:0]  n_fill;
    logic                       r_bank;
    logic                       n_bank;
    logic [wcb_pkg::WORD_W-1:0] r_base;
    logic [wcb_pkg::WORD_W-1:0] n_base;

    logic                       is_flush;
    logic                       held;
    logic [wcb_pkg::WORD_W-1:0] exp_addr;
    logic                       brk;
    logic                       full;
    logic                       start_req;
    logic                       acc;

    // Decode the item against the held line.
    always_comb begin
        is_flush  = (i_item.mode == wcb_pkg::MODE_FLUSH);
        held      = (r_fill != '0);
        exp_addr  = r_base + (wcb_pkg::WORD_W'(r_fill) << 2);
        brk       = !is_flush && held && (i_item.byte_address != exp_addr);
        full      = !is_flush && !brk &&
                    (r_fill == wcb_pkg::CNT_W'(wcb_pkg::LINE_WORDS - 1));
        start_req = (is_flush && held) || brk || full;
    end

    // An item that emits a line waits until the drain sequencer can take it.
    assign o_stall = i_valid && start_req && !i_drain_free;
    assign acc     = i_valid && !o_stall;

    // Line start command.
    always_comb begin
        o_cmd.valid = acc && start_req;
        o_cmd.bank  = r_bank;
        o_cmd.base  = r_base;
        o_cmd.fill  = full ? wcb_pkg::CNT_W'(wcb_pkg::LINE_WORDS) : r_fill;
    end

    // Word write: a broken sequence starts the new line in the other bank.
    always_comb begin
        o_we    = acc && !is_flush;
        o_wdata = i_item.data_word;
        if (brk) begin
            o_waddr = {~r_bank, {wcb_pkg::SLOT_W{1'b0}}};
        end else begin
            o_waddr = {r_bank, r_fill[wcb_pkg::SLOT_W-1:0]};
        end
    end

    // Next fill state.
    always_comb begin
        n_fill = r_fill;
        n_bank = r_bank;
        n_base = r_base;
        if (acc) begin
            if (is_flush) begin
                if (held) begin
                    n_fill = '0;
                    n_bank = ~r_bank;
                end
            end else if (brk) begin
                n_bank = ~r_bank;
                n_base = i_item.byte_address;
                n_fill = wcb_pkg::CNT_W'(1);
            end else begin
                if (!held) begin
                    n_base = i_item.byte_address;
                end
                if (full) begin
                    n_fill = '0;
                    n_bank = ~r_bank;
                end else begin
                    n_fill = r_fill + wcb_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_bank <= 1'b0;
            r_base <= '0;
        end else begin
            r_fill <= n_fill;
            r_bank <= n_bank;
            r_base <= n_base;
        end
    end

endmodule

FILE: sv/wcb_drain.sv
// ----------------------------------------------------------------------------
// Drain sequencer
// Reads a finished line from its bank one slot per cycle unless stalled, pads
// unfilled slots and presents the words through a stallable output register.
// ----------------------------------------------------------------------------
module wcb_drain (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  wcb_pkg::t_drain_cmd        i_cmd,
    output logic                       o_drain_free,
    output logic                       o_re,
    output logic [wcb_pkg::RAM_AW-1:0] o_raddr,
    input  logic [wcb_pkg::WORD_W-1:0] i_rdata,
    output logic                       o_valid,
    input  logic                       i_stall,
    output wcb_pkg::t_out_item         o_item
);

    // Sequencer registers.
    logic                       r_busy;
    logic                       r_bank;
    logic [wcb_pkg::SLOT_W-1:0] r_slot;
    logic [wcb_pkg::CNT_W-1:0]  r_fill;
    logic [wcb_pkg::WORD_W-1:0] r_base;

    // Read data stage.
    logic                       r_q_valid;
    logic [wcb_pkg::WORD_W-1:0] r_q_base;
    logic [wcb_pkg::SLOT_W-1:0] r_q_slot;
    logic                       r_q_pad;
    logic                       r_q_last;

    // Output register.
    logic                       r_out_valid;
    wcb_pkg::t_out_item         r_out_item;

    logic adv_out;
    logic adv_q;
    logic issue;
    logic last_slot;

    // Pipeline advance from the output backwards.
    assign adv_out   = !r_out_valid || !i_stall;
    assign adv_q     = !r_q_valid || adv_out;
    assign issue     = r_busy && adv_q;
    assign last_slot = (r_slot == wcb_pkg::SLOT_W'(wcb_pkg::LINE_WORDS - 1));

    assign o_drain_free = !r_busy || (adv_q && last_slot);
    assign o_re         = adv_q;
    assign o_raddr      = {r_bank, r_slot};

    // Slot sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= '0;
        end else if (i_cmd.valid) begin
            r_busy <= 1'b1;
            r_slot <= '0;
        end else if (issue) begin
            if (last_slot) begin
                r_busy <= 1'b0;
            end
            r_slot <= r_slot + wcb_pkg::SLOT_W'(1);
        end
    end

    // Line descriptor for the line being read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid) begin
            r_bank <= i_cmd.bank;
            r_fill <= i_cmd.fill;
            r_base <= i_cmd.base;
        end
    end

    // Read data stage, aligned with the memory's registered output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
        end else if (adv_q) begin
            r_q_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_q) begin
            r_q_base <= r_base;
            r_q_slot <= r_slot;
            r_q_pad  <= (wcb_pkg::CNT_W'(r_slot) >= r_fill);
            r_q_last <= last_slot;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_q_valid) begin
            r_out_item.line_address <= r_q_base;
            r_out_item.slot_index   <= 3'(r_q_slot);
            r_out_item.line_word    <= r_q_pad ? wcb_pkg::PAD_WORD : i_rdata;
            r_out_item.last_of_line <= r_q_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

endmodule

FILE: sv/flash_write_combining_buffer_top.sv
// ----------------------------------------------------------------------------
// Flash write-combining buffer
// Gathers 32-bit program words into whole flash lines and emits each line
// word by word, padding unfilled slots with all ones.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid, o_stall, i_item): a write item buffers one word;
//   a flush item emits the held line, if any. An item whose address does not
//   follow the last buffered word emits the held line and starts a new one.
//   Output channel (o_valid, i_stall, o_item): each emitted line appears as
//   LINE_WORDS items in slot order, the last one flagged by last_of_line.
//   Throughput: one item per cycle. The line memory has two banks, so one
//   line fills while the previous one drains. An item that would emit a
//   line is held off only while the previous line is still being read from
//   its bank. Each emitted line is read by the slot sequencer, passes the
//   read data stage and the output register, and leaves one word per cycle
//   while the receiver does not stall.
//   When the receiver stalls, the output register holds its item and the
//   memory reads pause behind it; input items that only buffer a word are
//   still taken.
//   Reset (i_rst_n low, synchronous) empties the buffer and the pipeline.
// ----------------------------------------------------------------------------
module flash_write_combining_buffer_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  wcb_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output wcb_pkg::t_out_item o_item
);

    wcb_pkg::t_drain_cmd        cmd;
    logic                       drain_free;
    logic                       we;
    logic [wcb_pkg::RAM_AW-1:0] waddr;
    logic [wcb_pkg::WORD_W-1:0] wdata;
    logic                       re;
    logic [wcb_pkg::RAM_AW-1:0] raddr;
    logic [wcb_pkg::WORD_W-1:0] rdata;

    // Item intake and line tracking.
    wcb_fill_ctrl u_fill (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_item       (i_item),
        .o_stall      (o_stall),
        .i_drain_free (drain_free),
        .o_cmd        (cmd),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata)
    );

    // Two-bank line memory.
    wcb_line_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Line readout.
    wcb_drain u_drain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_drain_free (drain_free),
        .o_re         (re),
        .o_raddr      (raddr),
        .i_rdata      (rdata),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_item       (o_item)
    );

`ifndef SYNTHESIS
    // A line is handed over only when the sequencer can take it.
    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.valid |-> drain_free)
        else $error("line started while the previous line is still being read");

    // An emitted line always holds at least one word and never more than a line.
    a_start_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.valid |-> (cmd.fill != '0) &&
                      (cmd.fill <= wcb_pkg::CNT_W'(wcb_pkg::LINE_WORDS)))
        else $error("line started with a bad fill count");

    // A line start that also writes into the other bank writes its slot zero.
    a_write_other_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.valid && we && (waddr[wcb_pkg::RAM_AW-1] != cmd.bank)) |->
            (waddr[wcb_pkg::SLOT_W-1:0] == '0))
        else $error("new line did not start at slot zero of the other bank");
`endif

endmodule

FILE: dv/tb_flash_write_combining_buffer_top.sv
// ----------------------------------------------------------------------------
// Flash write-combining buffer testbench
// Drives write and flush items into the buffer and checks every emitted line
// word against a line predictor kept in step with the accepted items. The
// run walks through directed corner cases, then random word runs under
// several idle and stall mixes, and a long output hold that backs the block
// up into its input.
// ----------------------------------------------------------------------------
module tb_flash_write_combining_buffer_top;

    // Output hold length for the back-pressure phase, in cycles.
    localparam int LONG_HOLD = 300;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    wcb_pkg::t_in_item  i_item = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    wcb_pkg::t_out_item o_item;

    // Items waiting to be offered, and line words still owed by the block.
    wcb_pkg::t_in_item  pending_items[$];
    wcb_pkg::t_out_item expected_words[$];

    // Line predictor state.
    logic [wcb_pkg::WORD_W-1:0] pred_words [wcb_pkg::LINE_WORDS];
    logic [wcb_pkg::WORD_W-1:0] pred_base;
    int                         pred_fill;

    // Traffic shaping; settings change on falling edges, hold counters on rising.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int holds_requested = 0;
    int holds_served;
    int hold_left;

    // Run statistics.
    int errors = 0;
    int items_accepted = 0;
    int words_checked = 0;
    int lines_checked = 0;

    // Next address the random generator would need to extend its last run.
    logic [wcb_pkg::WORD_W-1:0] gen_next_addr = '0;

    flash_write_combining_buffer_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Reset is held low at the start, then released for good.
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Queue every word of the held line, padding slots never filled.
    function automatic void emit_expected_line();
        wcb_pkg::t_out_item w;
        for (int k = 0; k < wcb_pkg::LINE_WORDS; k++) begin
            w.line_address = pred_base;
            w.slot_index   = 3'(k);
            w.line_word    = (k < pred_fill) ? pred_words[k] : wcb_pkg::PAD_WORD;
            w.last_of_line = (k == wcb_pkg::LINE_WORDS - 1);
            expected_words.push_back(w);
        end
        pred_fill = 0;
    endfunction

    // Advance the predictor by one accepted item.
    function automatic void predict_line_words(input wcb_pkg::t_in_item it);
        logic [wcb_pkg::WORD_W-1:0] follow_addr;
        follow_addr = pred_base + wcb_pkg::WORD_W'(pred_fill * 4);
        if (it.mode == wcb_pkg::MODE_FLUSH) begin
            if (pred_fill != 0) begin
                emit_expected_line();
            end
        end else begin
            // A word that does not follow the held run closes that line first.
            if (pred_fill > 0 && it.byte_address != follow_addr) begin
                emit_expected_line();
            end
            if (pred_fill == 0) begin
                pred_base = it.byte_address;
            end
            pred_words[pred_fill] = it.data_word;
            pred_fill++;
            if (pred_fill >= wcb_pkg::LINE_WORDS) begin
                emit_expected_line();
            end
        end
    endfunction

    function automatic void add_item(input logic m,
                                     input logic [wcb_pkg::WORD_W-1:0] addr,
                                     input logic [wcb_pkg::WORD_W-1:0] data);
        wcb_pkg::t_in_item it;
        it.mode         = m;
        it.byte_address = addr;
        it.data_word    = data;
        pending_items.push_back(it);
    endfunction

    // Mostly runs of consecutive words with random content, some flushes and
    // some stray writes that break a run.
    task automatic add_random_items(input int count);
        int                         added;
        int                         run_len;
        int                         choice;
        logic [wcb_pkg::WORD_W-1:0] addr;
        logic [wcb_pkg::WORD_W-1:0] data;
        added = 0;
        while (added < count) begin
            choice = $urandom_range(99);
            if (choice < 78) begin
                if (choice < 20) begin
                    addr = gen_next_addr;
                end else if (choice < 26) begin
                    addr = 32'hFFFF_FFE0 + 32'($urandom_range(7) * 4);
                end else if (choice < 32) begin
                    addr = $urandom;
                end else begin
                    addr = $urandom & 32'hFFFF_FFFC;
                end
                run_len = $urandom_range(1, 10);
                for (int j = 0; j < run_len; j++) begin
                    case ($urandom_range(9))
                        0:       data = '0;
                        1:       data = '1;
                        default: data = $urandom;
                    endcase
                    add_item(wcb_pkg::MODE_WRITE, addr, data);
                    addr = addr + 32'd4;
                    added++;
                end
                gen_next_addr = addr;
            end else if (choice < 92) begin
                add_item(wcb_pkg::MODE_FLUSH, $urandom, $urandom);
                added++;
            end else begin
                addr = $urandom;
                add_item(wcb_pkg::MODE_WRITE, addr, $urandom);
                gen_next_addr = addr + 32'd4;
                added++;
            end
        end
    endtask

    // Let the sender run dry, then wait for every owed line word.
    task automatic wait_until_drained();
        while (pending_items.size() != 0 || i_valid) @(negedge i_clk);
        while (expected_words.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_traffic(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Driver: offers the next pending item, holding it while stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_item  <= '0;
        end else if (!i_valid || !o_stall) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_item  <= pending_items.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long counted hold when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall      <= 1'b0;
            hold_left    = 0;
            holds_served = 0;
        end else if (holds_served != holds_requested) begin
            holds_served++;
            hold_left = LONG_HOLD - 1;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: checks each accepted line word, then folds in the accepted item.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pred_fill = 0;
            pred_base = '0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected line word: address %h slot %0d word %h last %b",
                           o_item.line_address, o_item.slot_index, o_item.line_word,
                           o_item.last_of_line);
                    errors++;
                end else begin
                    wcb_pkg::t_out_item want;
                    want = expected_words.pop_front();
                    if (o_item.line_address !== want.line_address) begin
                        $error("line_address: expected %h, got %h",
                               want.line_address, o_item.line_address);
                        errors++;
                    end
                    if (o_item.slot_index !== want.slot_index) begin
                        $error("slot_index: expected %0d, got %0d",
                               want.slot_index, o_item.slot_index);
                        errors++;
                    end
                    if (o_item.line_word !== want.line_word) begin
                        $error("line_word: expected %h, got %h",
                               want.line_word, o_item.line_word);
                        errors++;
                    end
                    if (o_item.last_of_line !== want.last_of_line) begin
                        $error("last_of_line: expected %b, got %b",
                               want.last_of_line, o_item.last_of_line);
                        errors++;
                    end
                    words_checked++;
                    if (want.last_of_line) begin
                        lines_checked++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                predict_line_words(i_item);
                items_accepted++;
            end
        end
    end

    // Stimulus sequence.
    initial begin
        while (!i_rst_n) @(negedge i_clk);
        repeat (3) @(negedge i_clk);

        // Directed corner cases, no idling.
        set_traffic(0, 0);
        add_item(wcb_pkg::MODE_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);    // flush while empty
        add_item(wcb_pkg::MODE_WRITE, 32'h0000_0000, 32'h0000_0000);
        add_item(wcb_pkg::MODE_FLUSH, 32'h0000_0000, 32'h0000_0000);    // one word, seven pads
        // A full line whose addresses wrap past the top of the address space.
        add_item(wcb_pkg::MODE_WRITE, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        add_item(wcb_pkg::MODE_WRITE, 32'hFFFF_FFF4, 32'h0000_0000);
        add_item(wcb_pkg::MODE_WRITE, 32'hFFFF_FFF8, 32'hA5A5_A5A5);
        add_item(wcb_pkg::MODE_WRITE, 32'hFFFF_FFFC, 32'h5A5A_5A5A);
        add_item(wcb_pkg::MODE_WRITE, 32'h0000_0000, 32'h8000_0000);
        add_item(wcb_pkg::MODE_WRITE, 32'h0000_0004, 32'h7FFF_FFFF);
        add_item(wcb_pkg::MODE_WRITE, 32'h0000_0008, 32'h0000_0001);
        add_item(wcb_pkg::MODE_WRITE, 32'h0000_000C, 32'hFFFF_FFFE);
        add_item(wcb_pkg::MODE_FLUSH, 32'h5555_5555, 32'hAAAA_AAAA);    // empty after full line
        // Address jumps close the held line.
        add_item(wcb_pkg::MODE_WRITE, 32'h0000_0100, 32'h1111_1111);
        add_item(wcb_pkg::MODE_WRITE, 32'h0000_0200, 32'h2222_2222);
        add_item(wcb_pkg::MODE_WRITE, 32'h0000_0003, 32'h3333_3333);    // unaligned start
        add_item(wcb_pkg::MODE_WRITE, 32'h0000_0007, 32'h4444_4444);
        add_item(wcb_pkg::MODE_FLUSH, 32'hAAAA_AAAA, 32'h5555_5555);
        add_item(wcb_pkg::MODE_FLUSH, 32'h0000_0000, 32'hFFFF_FFFF);    // second flush is empty
        add_item(wcb_pkg::MODE_WRITE, 32'h8000_0000, 32'h8000_0000);
        add_item(wcb_pkg::MODE_WRITE, 32'h7FFF_FFFC, 32'hFFFF_FFFF);    // backward jump
        add_item(wcb_pkg::MODE_WRITE, 32'h8000_0000, 32'h0000_0000);    // follows the new base
        add_item(wcb_pkg::MODE_FLUSH, 32'hFFFF_FFFF, 32'h0000_0000);
        wait_until_drained();

        // Random runs under each idle and stall mix.
        set_traffic(0, 0);
        add_random_items(15);
        wait_until_drained();

        set_traffic(63, 0);
        add_random_items(15);
        wait_until_drained();

        set_traffic(0, 63);
        add_random_items(15);
        wait_until_drained();

        set_traffic(24, 24);
        add_random_items(15);
        wait_until_drained();

        // Long output hold while three lines of words keep arriving.
        set_traffic(0, 0);
        holds_requested++;
        for (int n = 0; n < 3 * wcb_pkg::LINE_WORDS; n++) begin
            add_item(wcb_pkg::MODE_WRITE, 32'h0001_0000 + 32'(n * 4), $urandom);
        end
        add_random_items(4);
        add_item(wcb_pkg::MODE_FLUSH, $urandom, $urandom);
        wait_until_drained();

        // Quiet tail to catch stray line words.
        set_traffic(0, 0);
        repeat (2 * wcb_pkg::LINE_WORDS + 4) @(negedge i_clk);
        if (expected_words.size() != 0) begin
            $error("%0d line words never arrived", expected_words.size());
            errors++;
        end

        $display("Run covered %0d input items and %0d line words in %0d lines,",
                 items_accepted, words_checked, lines_checked);
        $display("with corner cases, idle and stall mixes and a long output hold.");
        if (errors == 0) begin
            $display("tb_flash_write_combining_buffer_top: PASS");
        end else begin
            $display("tb_flash_write_combining_buffer_top: FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("tb_flash_write_combining_buffer_top: FAIL");
        $finish;
    end

endmodule
